// File: rtl/core/mcu_port_latch_handshake_core_assert.svh
// ----------------------------------------------------------------------------
// MCU port latch handshake assertion macros
// Shared concurrent assertion forms for the port and mailbox core
// ----------------------------------------------------------------------------
`ifndef MCU_PORT_LATCH_HANDSHAKE_CORE_ASSERT_SVH
`define MCU_PORT_LATCH_HANDSHAKE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define MCUPLH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define MCUPLH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mcuplh_pkg.sv
// ----------------------------------------------------------------------------
// MCU port latch handshake package
// Access codes, flag bits and structs shared by the core and its port block
// ----------------------------------------------------------------------------
package mcuplh_pkg;

  localparam int unsigned FuncWidth = 4;
  localparam int unsigned ByteWidth = 8;

  // bus access selector
  typedef enum logic [FuncWidth-1:0] {
    FUNC_RD_A     = 4'd0,
    FUNC_WR_A     = 4'd1,
    FUNC_DDR_A    = 4'd2,
    FUNC_RD_B     = 4'd3,
    FUNC_WR_B     = 4'd4,
    FUNC_DDR_B    = 4'd5,
    FUNC_RD_C     = 4'd6,
    FUNC_WR_C     = 4'd7,
    FUNC_DDR_C    = 4'd8,
    FUNC_HOST_WR  = 4'd9,
    FUNC_HOST_RD  = 4'd10,
    FUNC_STAT1    = 4'd11,
    FUNC_STAT2    = 4'd12
  } func_e;

  // port C pin flags and status read values
  localparam logic [ByteWidth-1:0] FlagHostPending = 8'h01;
  localparam logic [ByteWidth-1:0] FlagMcuEmpty    = 8'h02;

  // port B handshake bits
  localparam int unsigned XferBit  = 1;
  localparam int unsigned LatchBit = 2;

  // one bus access
  typedef struct packed {
    func_e                func;
    logic [ByteWidth-1:0] data;
  } access_t;

  // result of one bus access
  typedef struct packed {
    logic [ByteWidth-1:0] read_data;
    logic                 mcu_irq;
  } result_t;

  // mailbox status seen by the top level
  typedef struct packed {
    logic host_pending;
    logic irq_level;
  } status_t;

endpackage

// File: rtl/core/mcuplh_ports.sv
// ----------------------------------------------------------------------------
// MCU port latch handshake port block
// Port registers, mailbox and flags; computes the result of one access
// ----------------------------------------------------------------------------
module mcuplh_ports (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                exec_i,         // apply access this cycle
  input  mcuplh_pkg::access_t                 access_i,
  input  logic [mcuplh_pkg::ByteWidth-1:0]    port_b_pins_i,
  output mcuplh_pkg::result_t                 result_o,
  output mcuplh_pkg::status_t                 status_o
);

  logic [mcuplh_pkg::ByteWidth-1:0] a_out_q, a_out_d;
  logic [mcuplh_pkg::ByteWidth-1:0] a_pins_q, a_pins_d;
  logic [mcuplh_pkg::ByteWidth-1:0] a_dir_q, a_dir_d;
  logic [mcuplh_pkg::ByteWidth-1:0] b_out_q, b_out_d;
  logic [mcuplh_pkg::ByteWidth-1:0] b_dir_q, b_dir_d;
  logic [mcuplh_pkg::ByteWidth-1:0] c_out_q, c_out_d;
  logic [mcuplh_pkg::ByteWidth-1:0] c_dir_q, c_dir_d;
  logic [mcuplh_pkg::ByteWidth-1:0] h2m_q, h2m_d;
  logic [mcuplh_pkg::ByteWidth-1:0] m2h_q, m2h_d;
  logic                             host_pend_q, host_pend_d;
  logic                             mcu_pend_q, mcu_pend_d;
  logic                             irq_q, irq_d;
  logic [mcuplh_pkg::ByteWidth-1:0] rd;
  logic [mcuplh_pkg::ByteWidth-1:0] c_pins;
  logic [mcuplh_pkg::ByteWidth-1:0] wdata;

  assign wdata = access_i.data;

  // port C pins reflect the mailbox flags
  always_comb begin
    c_pins = '0;
    if (host_pend_q) c_pins = c_pins | mcuplh_pkg::FlagHostPending;
    if (!mcu_pend_q) c_pins = c_pins | mcuplh_pkg::FlagMcuEmpty;
  end

  // next state and read data for the current access
  always_comb begin
    a_out_d     = a_out_q;
    a_pins_d    = a_pins_q;
    a_dir_d     = a_dir_q;
    b_out_d     = b_out_q;
    b_dir_d     = b_dir_q;
    c_out_d     = c_out_q;
    c_dir_d     = c_dir_q;
    h2m_d       = h2m_q;
    m2h_d       = m2h_q;
    host_pend_d = host_pend_q;
    mcu_pend_d  = mcu_pend_q;
    irq_d       = irq_q;
    rd          = '0;
    case (access_i.func)
      mcuplh_pkg::FUNC_RD_A:  rd = (a_out_q & a_dir_q) | (a_pins_q & ~a_dir_q);
      mcuplh_pkg::FUNC_WR_A:  a_out_d = wdata;
      mcuplh_pkg::FUNC_DDR_A: a_dir_d = wdata;
      mcuplh_pkg::FUNC_RD_B:  rd = (b_out_q & b_dir_q) | (port_b_pins_i & ~b_dir_q);
      mcuplh_pkg::FUNC_WR_B: begin
        // falling edge on bit 1 hands the host byte to port A
        if (b_dir_q[mcuplh_pkg::XferBit] && !wdata[mcuplh_pkg::XferBit] &&
            b_out_q[mcuplh_pkg::XferBit]) begin
          a_pins_d    = h2m_q;
          host_pend_d = 1'b0;
          irq_d       = 1'b0;
        end
        // rising edge on bit 2 latches port A output for the host
        if (b_dir_q[mcuplh_pkg::LatchBit] && wdata[mcuplh_pkg::LatchBit] &&
            !b_out_q[mcuplh_pkg::LatchBit]) begin
          m2h_d      = a_out_q;
          mcu_pend_d = 1'b1;
        end
        b_out_d = wdata;
      end
      mcuplh_pkg::FUNC_DDR_B: b_dir_d = wdata;
      mcuplh_pkg::FUNC_RD_C:  rd = (c_out_q & c_dir_q) | (c_pins & ~c_dir_q);
      mcuplh_pkg::FUNC_WR_C:  c_out_d = wdata;
      mcuplh_pkg::FUNC_DDR_C: c_dir_d = wdata;
      mcuplh_pkg::FUNC_HOST_WR: begin
        h2m_d       = wdata;
        host_pend_d = 1'b1;
        irq_d       = 1'b1;
      end
      mcuplh_pkg::FUNC_HOST_RD: begin
        mcu_pend_d = 1'b0;
        rd         = m2h_q;
      end
      mcuplh_pkg::FUNC_STAT1: rd = mcu_pend_q ? mcuplh_pkg::FlagMcuEmpty : '0;
      mcuplh_pkg::FUNC_STAT2: rd = host_pend_q ? '0 : mcuplh_pkg::FlagHostPending;
      default: rd = '0;
    endcase
  end

  // state registers, updated when an access executes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_out_q     <= '0;
      a_pins_q    <= '0;
      a_dir_q     <= '0;
      b_out_q     <= '0;
      b_dir_q     <= '0;
      c_out_q     <= '0;
      c_dir_q     <= '0;
      h2m_q       <= '0;
      m2h_q       <= '0;
      host_pend_q <= 1'b0;
      mcu_pend_q  <= 1'b0;
      irq_q       <= 1'b0;
    end else if (exec_i) begin
      a_out_q     <= a_out_d;
      a_pins_q    <= a_pins_d;
      a_dir_q     <= a_dir_d;
      b_out_q     <= b_out_d;
      b_dir_q     <= b_dir_d;
      c_out_q     <= c_out_d;
      c_dir_q     <= c_dir_d;
      h2m_q       <= h2m_d;
      m2h_q       <= m2h_d;
      host_pend_q <= host_pend_d;
      mcu_pend_q  <= mcu_pend_d;
      irq_q       <= irq_d;
    end
  end

  assign result_o.read_data    = rd;
  assign result_o.mcu_irq      = irq_d;
  assign status_o.host_pending = host_pend_q;
  assign status_o.irq_level    = irq_q;

endmodule

// File: rtl/core/mcu_port_latch_handshake_core.sv
// ----------------------------------------------------------------------------
// MCU port latch handshake core
// Three MCU ports with direction registers and a host mailbox, one access
// per transaction
// ----------------------------------------------------------------------------
//  channel   | dir | tdata             | tuser      | notes
//  s_axis    | in  | [7:0] data        | [3:0] func | one bus access
//  m_axis    | out | [7:0] read_data   | [0] mcu_irq| one result per access
//  cfg       | in  | [7:0] port_b_pins | -          | write enable, no read-back
//
//  One access per clock while m_axis_tready is high; each access passes
//  from the input register through the port logic into the result register.
//  The port logic updates its state as an access moves into the result
//  register, so a stalled output holds the input stage and then s_axis.
//  Reset clears all port, mailbox and flag state; port_b_pins resets to ones.
// ----------------------------------------------------------------------------
`include "mcu_port_latch_handshake_core_assert.svh"

module mcu_port_latch_handshake_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // access in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data
  input  logic [3:0] s_axis_tuser,   // [3:0] func
  // result out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] read_data
  output logic [0:0] m_axis_tuser,   // [0] mcu_irq
  // port B pin level
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic                      in_valid_q;
  mcuplh_pkg::access_t       in_q;
  logic                      out_valid_q;
  mcuplh_pkg::result_t       out_q;
  logic                      advance;
  logic                      s_take;
  logic [mcuplh_pkg::ByteWidth-1:0] pb_pins_q;
  mcuplh_pkg::result_t       result;
  mcuplh_pkg::status_t       status;

  // pipeline moves when the result register is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  // port B pin level register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_pins_q <= '1;
    end else if (cfg_we_i) begin
      pb_pins_q <= cfg_wdata_i;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_q.func <= mcuplh_pkg::func_e'(s_axis_tuser);
      in_q.data <= s_axis_tdata;
    end
  end

  mcuplh_ports u_ports (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .exec_i        (advance),
    .access_i      (in_q),
    .port_b_pins_i (pb_pins_q),
    .result_o      (result),
    .status_o      (status)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_q.read_data;
  assign m_axis_tuser[0] = out_q.mcu_irq;

  // interrupt follows the host pending flag exactly
  `MCUPLH_ASSERT_SAME(a_irq_tracks_pending, 1'b1,
                      status.irq_level == status.host_pending,
                      "irq level differs from host pending flag")

  // a waiting result carries the current interrupt level
  `MCUPLH_ASSERT_SAME(a_out_irq_current, m_axis_tvalid,
                      m_axis_tuser[0] == status.irq_level,
                      "result irq does not match port state")

  // a held access is not dropped
  `MCUPLH_ASSERT_NEXT(a_in_held, in_valid_q && !advance, in_valid_q,
                      "stalled access lost from input register")

  // port A, port B and host write accesses return zero data
  `MCUPLH_ASSERT_NEXT(a_write_zero,
                      advance && (in_q.func == mcuplh_pkg::FUNC_WR_A ||
                                  in_q.func == mcuplh_pkg::FUNC_WR_B ||
                                  in_q.func == mcuplh_pkg::FUNC_HOST_WR),
                      m_axis_tdata == '0,
                      "write access returned nonzero data")

endmodule
